[design/dma_slot_allocation_table_defines.svh]
// Assertion macros shared by the slot allocation table RTL.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef DMA_SLOT_ALLOCATION_TABLE_DEFINES_SVH
`define DMA_SLOT_ALLOCATION_TABLE_DEFINES_SVH

// same-cycle implication
`define DSAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dsat_pkg.sv]
// Package for the DMA slot allocation table: types, codes and constants.
// No dependencies.
`default_nettype none

package dsat_pkg;

    localparam int LAST_SLOT = 226;
    localparam int SLOTS     = LAST_SLOT + 1;
    localparam int SLOT_W    = 8;
    localparam int OWNER_W   = 5;
    localparam int CTRL_W    = 11;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [15:0]     CTL_SET_FLAG = 16'h8000;
    localparam logic [CTRL_W-1:0] CTL_MASK   = 11'h7FF;
    localparam int BIT_MASTER = 9;
    localparam int BIT_PLANES = 8;
    localparam int BIT_SPRITE = 5;
    localparam int BIT_DISK   = 4;

    localparam logic [7:0] FETCH_MIN   = 8'h18;
    localparam logic [7:0] FETCH_MAX   = 8'hD7;
    localparam logic [7:0] GROUP_ALIGN = 8'hF8;
    localparam logic [7:0] STOP_OFFSET = 8'd16;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FETCH_START = 3'd0,
        REG_FETCH_STOP  = 3'd1,
        REG_HIRES       = 3'd2,
        REG_PLANES      = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] write_value;
        logic [7:0]  slot_position;
    } cmd_t;

    typedef struct packed {
        logic [OWNER_W-1:0] slot_owner;
        logic [SLOT_W-1:0]  next_slot;
        logic [CTRL_W-1:0]  control_readback;
    } result_t;

    typedef struct packed {
        logic [7:0] fetch_start;
        logic [7:0] fetch_stop;
        logic       high_resolution;
        logic [2:0] plane_count;
    } cfg_t;

    // table write beat from the builder
    typedef struct packed {
        logic               we;
        logic               last;
        logic [SLOT_W-1:0]  addr;
        logic [OWNER_W-1:0] owner;
        logic [SLOT_W-1:0]  next_slot;
    } bld_t;

endpackage

`default_nettype wire

[design/dma_slot_allocation_table.sv]
// DMA slot allocation table, top level: command channel, control register,
// config registers and the two slot tables. Depends on dsat_pkg, dsat_ram,
// dsat_builder and dma_slot_allocation_table_defines.svh.
//
// Use: drive cmd and raise start; the beat is taken on an edge with busy low.
// kind = write updates the DMA control word (bit 15 set ORs, clear clears),
// then the owner and next-slot tables are rebuilt by a sweep over all 227
// slots, one slot a cycle; busy stays high until the sweep ends.
// kind = lookup reads both tables for slot_position: busy for one cycle.
// Every beat gives one result, shown on result for one cycle with done high.
// A control write answers in the cycle after acceptance; a lookup answers
// after ST_LOOKUP, which waits on the table read. The receiver cannot stall.
// Lookups: a new one is taken only after the last has left ST_LOOKUP.
// Control writes: a new beat is taken only after the rebuild sweep ends.
// Config writes (cfg_we) reach the tables at the next sweep, or a running one.
// Reset: control and config clear, and the same sweep zeroes both tables,
// so busy is high after reset until that sweep ends.
`default_nettype none
`include "dma_slot_allocation_table_defines.svh"

module dma_slot_allocation_table
    import dsat_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire cmd_t                 cmd,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_BUILD  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CTRL_W-1:0] ctrl_reg, ctrl_next;
    cfg_t              cfg_reg;
    logic              oob_reg, oob_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic               accept;
    logic               bld_load;
    bld_t               bld;
    logic               rd_en;
    logic [OWNER_W-1:0] rd_owner;
    logic [SLOT_W-1:0]  rd_next;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign rd_en  = accept && (cmd.kind == KIND_LOOKUP);

    dsat_builder u_builder (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (bld_load),
        .en    (state_reg == ST_BUILD),
        .ctrl  (ctrl_reg),
        .cfg   (cfg_reg),
        .bld   (bld)
    );

    // reads only happen while no sweep runs, so no forwarding is needed
    dsat_ram #(.WIDTH(OWNER_W), .DEPTH(SLOTS)) u_owner_ram (
        .clk   (clk),
        .we    (bld.we),
        .waddr (bld.addr),
        .wdata (bld.owner),
        .re    (rd_en),
        .raddr (cmd.slot_position),
        .rdata (rd_owner)
    );

    dsat_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (bld.we),
        .waddr (bld.addr),
        .wdata (bld.next_slot),
        .re    (rd_en),
        .raddr (cmd.slot_position),
        .rdata (rd_next)
    );

    always_comb
    begin
        state_next  = state_reg;
        ctrl_next   = ctrl_reg;
        oob_next    = oob_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        bld_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_WRITE)
                    begin
                        if ((cmd.write_value & CTL_SET_FLAG) != '0)
                        begin
                            ctrl_next = ctrl_reg | cmd.write_value[CTRL_W-1:0];
                        end
                        else
                        begin
                            ctrl_next = ctrl_reg & ~cmd.write_value[CTRL_W-1:0];
                        end
                        ctrl_next                    = ctrl_next & CTL_MASK;
                        result_next.slot_owner       = '0;
                        result_next.next_slot        = '0;
                        result_next.control_readback = ctrl_next;
                        done_next                    = 1'b1;
                        bld_load                     = 1'b1;
                        state_next                   = ST_BUILD;
                    end
                    else
                    begin
                        oob_next   = (cmd.slot_position > SLOT_W'(LAST_SLOT));
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                done_next                    = 1'b1;
                result_next.slot_owner       = oob_reg ? '0 : rd_owner;
                result_next.next_slot        = oob_reg ? '0 : rd_next;
                result_next.control_readback = ctrl_reg;
                state_next                   = ST_IDLE;
            end
            ST_BUILD:
            begin
                if (bld.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            ctrl_reg  <= '0;
            oob_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cfg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctrl_reg  <= ctrl_next;
            oob_reg   <= oob_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FETCH_START: cfg_reg.fetch_start     <= cfg_wdata;
                    REG_FETCH_STOP:  cfg_reg.fetch_stop      <= cfg_wdata;
                    REG_HIRES:       cfg_reg.high_resolution <= cfg_wdata[0];
                    REG_PLANES:      cfg_reg.plane_count     <= cfg_wdata[2:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `DSAT_ASSERT_NEXT(a_lookup_result, state_reg == ST_LOOKUP, done,
        "lookup beat gave no result")
    `DSAT_ASSERT_NEXT(a_oob_zero, state_reg == ST_LOOKUP && oob_reg,
        result.slot_owner == '0 && result.next_slot == '0,
        "out-of-range lookup returned an owner")
    `DSAT_ASSERT_NEXT(a_write_result, accept && cmd.kind == KIND_WRITE,
        done && result.slot_owner == '0 && state_reg == ST_BUILD,
        "control write did not answer and start the sweep")
    `DSAT_ASSERT_NOW(a_owner_range, done, result.slot_owner <= 5'd23,
        "owner code out of range")

endmodule

`default_nettype wire

[design/dsat_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dsat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/dsat_builder.sv]
// Table rebuild sweep: walks the slots from last to first, works out each
// owner and the running next-owned slot. Depends on dsat_pkg.
`default_nettype none

module dsat_builder
    import dsat_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              en,
    input  wire logic [CTRL_W-1:0] ctrl,
    input  wire cfg_t              cfg,
    output bld_t                   bld
);

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] nxt_reg, nxt_next;
    logic [OWNER_W-1:0] owner;

    function automatic logic [OWNER_W-1:0] owner_of(
        input logic [SLOT_W-1:0] s,
        input logic [CTRL_W-1:0] c,
        input cfg_t              f
    );
        logic [7:0] start;
        logic [7:0] stop_raw;
        logic [7:0] stop;
        logic [7:0] base_min;
        logic [7:0] base;
        logic [7:0] diff;
        logic [2:0] pl;
        logic [2:0] p;
        logic [OWNER_W-1:0] o;
        o        = '0;
        start    = (f.fetch_start < FETCH_MIN) ? FETCH_MIN : f.fetch_start;
        stop_raw = f.fetch_stop + STOP_OFFSET;
        stop     = (stop_raw > FETCH_MAX) ? FETCH_MAX : stop_raw;
        base_min = start & GROUP_ALIGN;
        diff     = s - 8'd21;
        if (c[BIT_MASTER])
        begin
            if (c[BIT_DISK] && (s == 8'd7 || s == 8'd9 || s == 8'd11))
            begin
                o = 5'd1;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (c[k] && s == 8'(13 + 2 * k))
                begin
                    o = 5'(2 + k);
                end
            end
            if (c[BIT_SPRITE] && s >= 8'd21 && s <= 8'd51 && s[0])
            begin
                o = 5'd6 + {2'b00, diff[4:2]};
            end
            if (c[BIT_PLANES])
            begin
                if (f.high_resolution)
                begin
                    pl   = (f.plane_count == 3'd5 || f.plane_count == 3'd6)
                           ? 3'd4 : f.plane_count;
                    base = {s[7:2], 2'b00};
                    p    = 3'd4 - {1'b0, s[1:0]};
                    if (f.plane_count != 3'd7 && base >= base_min && base < stop
                        && p <= pl)
                    begin
                        o = 5'd19 + {2'b00, p};
                    end
                end
                else
                begin
                    base = {s[7:3], 3'b000};
                    case (s[2:0])
                        3'd7:    p = 3'd1;
                        3'd3:    p = 3'd2;
                        3'd5:    p = 3'd3;
                        3'd1:    p = 3'd4;
                        3'd6:    p = 3'd5;
                        3'd2:    p = 3'd6;
                        default: p = 3'd0;
                    endcase
                    if (f.plane_count != 3'd7 && base >= base_min && base < stop
                        && p != 3'd0 && p <= f.plane_count)
                    begin
                        o = 5'd13 + {2'b00, p};
                    end
                end
            end
        end
        return o;
    endfunction

    assign owner = owner_of(idx_reg, ctrl, cfg);

    always_comb
    begin
        idx_next = idx_reg;
        nxt_next = nxt_reg;
        if (load)
        begin
            idx_next = SLOT_W'(LAST_SLOT);
            nxt_next = '0;
        end
        else if (en)
        begin
            if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
            if (owner != '0)
            begin
                nxt_next = idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= SLOT_W'(LAST_SLOT);
            nxt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            nxt_reg <= nxt_next;
        end
    end

    assign bld.we        = en;
    assign bld.last      = en && (idx_reg == '0);
    assign bld.addr      = idx_reg;
    assign bld.owner     = owner;
    assign bld.next_slot = nxt_reg;

endmodule

`default_nettype wire
